// File: src/prd_pkg.sv
// shared constants and types for the prime range density block
// no dependencies
package prd_pkg;

	localparam int unsigned MAX_VALUE = 65536;
	localparam int unsigned DEPTH     = MAX_VALUE + 1;
	localparam int unsigned ADDR_W    = $clog2(DEPTH);
	localparam int unsigned IN_W      = 17;
	localparam int unsigned CNT_W     = 13;
	localparam int unsigned FRAC_BITS = 20;
	localparam int unsigned QUO_W     = FRAC_BITS + 1;
	localparam int unsigned SPAN_W    = IN_W + 1;
	localparam int unsigned S_DATA_W  = 40;
	localparam int unsigned M_DATA_W  = 40;

	localparam logic [ADDR_W-1:0] MAX_ADDR = ADDR_W'(MAX_VALUE);

	// one write into the prefix count tables
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  data;
	} cnt_wr_t;

endpackage

// File: src/prd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module prd_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: src/prd_sieve.sv
// table builder: sieve over a composite-flag ram, then a sweep that emits prefix counts
// depends on prd_pkg and prd_ram
module prd_sieve (
	input  logic            clk,
	input  logic            arst_n,
	output prd_pkg::cnt_wr_t cnt_wr,
	output logic            table_ready
);
	import prd_pkg::*;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_SREAD = 6'b000010,
		ST_SCHK  = 6'b000100,
		ST_MARK  = 6'b001000,
		ST_COUNT = 6'b010000,
		ST_DONE  = 6'b100000
	} sv_state_t;

	sv_state_t           state_q;
	logic [ADDR_W-1:0]   idx_q;
	logic [ADDR_W:0]     mult_q;
	logic [ADDR_W-1:0]   cidx_q;
	logic                cvalid_q;
	logic [CNT_W-1:0]    run_q;

	logic                f_we;
	logic [ADDR_W-1:0]   f_waddr;
	logic                f_wdata;
	logic                f_re;
	logic                f_rdata;
	logic [2*ADDR_W-1:0] square;
	logic [ADDR_W:0]     mult_next;
	logic                is_prime;
	logic [CNT_W-1:0]    run_next;

	assign square    = (2*ADDR_W)'(idx_q) * (2*ADDR_W)'(idx_q);
	assign mult_next = mult_q + (ADDR_W+1)'(idx_q);
	assign is_prime  = !f_rdata && (cidx_q >= ADDR_W'(2));
	assign run_next  = run_q + CNT_W'(is_prime);

	always_comb begin
		f_we    = 1'b0;
		f_waddr = idx_q;
		f_wdata = 1'b0;
		f_re    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				f_we = 1'b1;
			end
			ST_SREAD: begin
				f_re = 1'b1;
			end
			ST_MARK: begin
				f_we    = 1'b1;
				f_waddr = mult_q[ADDR_W-1:0];
				f_wdata = 1'b1;
			end
			ST_COUNT: begin
				f_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// flag ram holds 1 for a composite value
	prd_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_flag_ram (
		.clk  (clk),
		.we   (f_we),
		.waddr(f_waddr),
		.wdata(f_wdata),
		.re   (f_re),
		.raddr(idx_q),
		.rdata(f_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			idx_q    <= '0;
			mult_q   <= '0;
			cidx_q   <= '0;
			cvalid_q <= 1'b0;
			run_q    <= '0;
		end else begin
			cvalid_q <= (state_q == ST_COUNT);
			cidx_q   <= idx_q;
			unique case (state_q)
				ST_CLEAR: begin
					if (idx_q == MAX_ADDR) begin
						idx_q   <= ADDR_W'(2);
						state_q <= ST_SREAD;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SREAD: begin
					state_q <= ST_SCHK;
				end
				ST_SCHK: begin
					if (square > (2*ADDR_W)'(MAX_VALUE)) begin
						idx_q   <= '0;
						run_q   <= '0;
						state_q <= ST_COUNT;
					end else if (!f_rdata) begin
						mult_q  <= (ADDR_W+1)'(square);
						state_q <= ST_MARK;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SREAD;
					end
				end
				ST_MARK: begin
					if (mult_next > (ADDR_W+1)'(MAX_VALUE)) begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SREAD;
					end else begin
						mult_q <= mult_next;
					end
				end
				ST_COUNT: begin
					if (idx_q != MAX_ADDR) begin
						idx_q <= idx_q + 1'b1;
					end
					if (cvalid_q) begin
						run_q <= run_next;
						if (cidx_q == MAX_ADDR) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign cnt_wr.we    = (state_q == ST_COUNT) && cvalid_q;
	assign cnt_wr.addr  = cidx_q;
	assign cnt_wr.data  = run_next;
	assign table_ready  = (state_q == ST_DONE);

endmodule

// File: src/prime_range_density.sv
// Prime range density: counts primes in low..high and the prime share of the range as
// a 20 fractional bit fraction. After reset the block builds its tables and holds s_tready
// low: a clearing pass over MAX_VALUE+1 flag entries, the sieve (a flag read for each
// value up to the square root, and for each prime the marking of its multiples from its
// square), then a prefix count sweep over the table. From then on it takes one query word
// per cycle while the output skid register is empty; a result passes through the count ram
// read, the 21 stage restoring divider, one quotient bit per stage, and the output register.
// An output skid register lets the pipeline keep accepting for one word while m_tready is low.
// depends on prd_pkg, prd_ram and prd_sieve
module prime_range_density (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [prd_pkg::S_DATA_W-1:0]  s_tdata,   // range_low, range_high
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [prd_pkg::M_DATA_W-1:0]  m_tdata,   // prime_total, prime_fraction
	output logic                          m_tuser    // empty_range
);
	import prd_pkg::*;

	localparam int unsigned NDIV = FRAC_BITS;

	typedef struct packed {
		logic              v;
		logic [CNT_W-1:0]  total;
		logic [SPAN_W-1:0] span;
		logic [SPAN_W-1:0] rem;
		logic [QUO_W-1:0]  quo;
		logic              empty;
	} div_t;

	cnt_wr_t           cnt_wr;
	logic              table_ready;
	logic              en;
	logic              accept;
	logic [IN_W-1:0]   in_lo;
	logic [IN_W-1:0]   in_hi;
	logic [IN_W-1:0]   lo_dec;
	logic [ADDR_W-1:0] hi_addr;
	logic [ADDR_W-1:0] lo_addr;
	logic [CNT_W-1:0]  cnt_hi;
	logic [CNT_W-1:0]  cnt_lo;

	logic              v_s1;
	logic [IN_W-1:0]   lo_s1;
	logic [IN_W-1:0]   hi_s1;

	div_t              div_d [NDIV+1];
	div_t              div_q [NDIV+1];
	div_t              out_q;
	div_t              skid_q;

	logic [CNT_W-1:0]  below;
	logic [CNT_W-1:0]  tot0;
	logic [SPAN_W-1:0] span0;
	logic              ge0;

	prd_sieve u_sieve (
		.clk        (clk),
		.arst_n     (arst_n),
		.cnt_wr     (cnt_wr),
		.table_ready(table_ready)
	);

	assign in_lo  = s_tdata[IN_W-1:0];
	assign in_hi  = s_tdata[2*IN_W-1:IN_W];
	assign lo_dec = in_lo - 1'b1;

	// bounds past the table read the last entry
	assign hi_addr = (32'(in_hi) > MAX_VALUE) ? MAX_ADDR : ADDR_W'(in_hi);
	assign lo_addr = (32'(lo_dec) > MAX_VALUE) ? MAX_ADDR : ADDR_W'(lo_dec);

	assign en       = !skid_q.v;
	assign s_tready = table_ready && en;
	assign accept   = s_tvalid && s_tready;

	prd_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_cnt_hi_ram (
		.clk  (clk),
		.we   (cnt_wr.we),
		.waddr(cnt_wr.addr),
		.wdata(cnt_wr.data),
		.re   (en),
		.raddr(hi_addr),
		.rdata(cnt_hi)
	);

	prd_ram #(
		.WIDTH(CNT_W),
		.DEPTH(DEPTH)
	) u_cnt_lo_ram (
		.clk  (clk),
		.we   (cnt_wr.we),
		.waddr(cnt_wr.addr),
		.wdata(cnt_wr.data),
		.re   (en),
		.raddr(lo_addr),
		.rdata(cnt_lo)
	);

	assign below = (lo_s1 == '0) ? '0 : cnt_lo;
	assign tot0  = (hi_s1 < lo_s1) ? '0 : (cnt_hi - below);
	assign span0 = SPAN_W'(hi_s1) - SPAN_W'(lo_s1) + 1'b1;
	assign ge0   = (hi_s1 >= lo_s1) && (SPAN_W'(tot0) >= span0);

	always_comb begin
		logic [SPAN_W:0] r2;
		logic            ge;
		div_d[0].v     = v_s1;
		div_d[0].total = tot0;
		div_d[0].span  = span0;
		div_d[0].empty = (hi_s1 < lo_s1);
		div_d[0].quo   = QUO_W'(ge0);
		div_d[0].rem   = ge0 ? (SPAN_W'(tot0) - span0) : SPAN_W'(tot0);
		for (int k = 1; k <= NDIV; k++) begin
			r2           = {div_q[k-1].rem, 1'b0};
			ge           = (div_q[k-1].span != '0) && (r2 >= {1'b0, div_q[k-1].span});
			div_d[k]     = div_q[k-1];
			div_d[k].quo = {div_q[k-1].quo[QUO_W-2:0], ge};
			div_d[k].rem = ge ? SPAN_W'(r2 - {1'b0, div_q[k-1].span}) : SPAN_W'(r2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			lo_s1 <= '0;
			hi_s1 <= '0;
			for (int k = 0; k <= NDIV; k++) begin
				div_q[k] <= '0;
			end
		end else if (en) begin
			v_s1  <= accept;
			lo_s1 <= in_lo;
			hi_s1 <= in_hi;
			for (int k = 0; k <= NDIV; k++) begin
				div_q[k] <= div_d[k];
			end
		end
	end

	// output word plus one skid word; pipeline stalls only while the skid is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= '0;
			skid_q <= '0;
		end else if (!out_q.v || m_tready) begin
			if (skid_q.v) begin
				out_q    <= skid_q;
				skid_q.v <= 1'b0;
			end else begin
				out_q <= div_q[NDIV];
			end
		end else if (div_q[NDIV].v && !skid_q.v) begin
			skid_q <= div_q[NDIV];
		end
	end

	assign m_tvalid = out_q.v;
	assign m_tdata  = M_DATA_W'({out_q.quo, out_q.total});
	assign m_tuser  = out_q.empty;

endmodule
